@@ rtl/core/dca_pkg.sv @@
// types, bit constants and access codes shared by the crosslinked adapter pair
package dca_pkg;

    // status bits
    localparam logic [7:0] ST_RDRF  = 8'h01;
    localparam logic [7:0] ST_TDRE  = 8'h02;
    localparam logic [7:0] ST_OVRN  = 8'h20;
    localparam logic [7:0] ST_IRQ   = 8'h80;
    localparam logic [7:0] ST_RXANY = 8'h21;

    // control bits
    localparam logic [7:0] CT_RIE    = 8'h80;
    localparam logic [7:0] CT_TXMASK = 8'h60;
    localparam logic [7:0] CT_TIE    = 8'h20;
    localparam logic [1:0] CT_MRESET = 2'b11;

    // access codes
    localparam logic SIDE_FIRST  = 1'b0;
    localparam logic SIDE_SECOND = 1'b1;
    localparam logic MODE_READ   = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;
    localparam logic SEL_STATUS  = 1'b0;
    localparam logic SEL_DATA    = 1'b1;

    typedef struct packed {
        logic       side;
        logic       mode;
        logic       reg_sel;
        logic [7:0] write_data;
    } dca_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_first;
        logic       irq_second;
    } dca_out_t;

    // per-side command for one access
    typedef struct packed {
        logic       update;
        logic       clr_rx;
        logic       ctrl_we;
        logic       tx_send;
        logic       rx_load;
        logic [7:0] wdata;
    } dca_side_cmd_t;

    // per-side view of current and next state
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] rx_data;
        logic [7:0] control;
        logic [7:0] status_next;
    } dca_side_view_t;

endpackage

@@ rtl/core/dca_side.sv @@
// one adapter: status, control and received byte with their update logic
module dca_side (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dca_pkg::dca_side_cmd_t cmd,
    output dca_pkg::dca_side_view_t view
);

    logic [7:0] status_reg, status_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] rx_reg, rx_next;
    logic       irq;

    always_comb begin
        status_next  = status_reg;
        control_next = cmd.ctrl_we ? cmd.wdata : control_reg;
        rx_next      = rx_reg;
        irq          = 1'b0;

        if (cmd.clr_rx) begin
            status_next = status_next & ~dca_pkg::ST_RXANY;
        end
        // transfer finishes within the access, so transmit-empty ends up set
        if (cmd.tx_send) begin
            status_next = status_next | dca_pkg::ST_TDRE;
        end
        if (cmd.rx_load) begin
            if ((status_next & dca_pkg::ST_RDRF) != 8'h00) begin
                status_next = status_next | dca_pkg::ST_OVRN;
            end
            status_next = status_next | dca_pkg::ST_RDRF;
            rx_next     = cmd.wdata;
        end
        if (cmd.update) begin
            if (control_next[1:0] == dca_pkg::CT_MRESET) begin
                status_next = dca_pkg::ST_TDRE;
            end
            if (((control_next & dca_pkg::CT_RIE) != 8'h00)
                    && ((status_next & dca_pkg::ST_RXANY) != 8'h00)) begin
                irq = 1'b1;
            end
            if (((control_next & dca_pkg::CT_TXMASK) == dca_pkg::CT_TIE)
                    && ((status_next & dca_pkg::ST_TDRE) != 8'h00)) begin
                irq = 1'b1;
            end
            if (irq) begin
                status_next = status_next | dca_pkg::ST_IRQ;
            end else begin
                status_next = status_next & ~dca_pkg::ST_IRQ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= 8'h00;
            control_reg <= 8'h00;
            rx_reg      <= 8'h00;
        end else begin
            status_reg  <= status_next;
            control_reg <= control_next;
            rx_reg      <= rx_next;
        end
    end

    assign view.status      = status_reg;
    assign view.rx_data     = rx_reg;
    assign view.control     = control_reg;
    assign view.status_next = status_next;

endmodule

@@ rtl/core/dual_acia_crosslink.sv @@
// top level: input register, two crosslinked adapters, result register
// Two serial adapters wired back to back, accessed one bus access per item.
// An item enters the input register and is applied to both adapters once the
// result register can take it, while its result is written to the result
// register, so one item is accepted every cycle while no result is held, and
// its result shows on m_valid from the result register. The adapter state update is a single pass
// of logic between the input register and the result register; a stalled
// result holds the input register, which keeps taking items whenever it is
// empty or moving.
module dual_acia_crosslink (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dca_pkg::dca_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dca_pkg::dca_out_t m_data
);

    dca_pkg::dca_in_t       in_reg;
    logic                   in_valid_reg, in_valid_next;
    dca_pkg::dca_out_t      out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   advance;
    logic                   is_write, is_data, needs_update;
    dca_pkg::dca_side_cmd_t cmd0, cmd1;
    dca_pkg::dca_side_view_t view0, view1;
    dca_pkg::dca_side_view_t view_sel;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign is_write     = (in_reg.mode == dca_pkg::MODE_WRITE);
    assign is_data      = (in_reg.reg_sel == dca_pkg::SEL_DATA);
    // a status read leaves both sides untouched
    assign needs_update = advance && (is_write || is_data);

    always_comb begin
        cmd0.update  = needs_update;
        cmd0.clr_rx  = advance && !is_write && is_data
                       && (in_reg.side == dca_pkg::SIDE_FIRST);
        cmd0.ctrl_we = advance && is_write && !is_data
                       && (in_reg.side == dca_pkg::SIDE_FIRST);
        cmd0.tx_send = advance && is_write && is_data
                       && (in_reg.side == dca_pkg::SIDE_FIRST);
        cmd0.rx_load = advance && is_write && is_data
                       && (in_reg.side == dca_pkg::SIDE_SECOND);
        cmd0.wdata   = in_reg.write_data;

        cmd1.update  = needs_update;
        cmd1.clr_rx  = advance && !is_write && is_data
                       && (in_reg.side == dca_pkg::SIDE_SECOND);
        cmd1.ctrl_we = advance && is_write && !is_data
                       && (in_reg.side == dca_pkg::SIDE_SECOND);
        cmd1.tx_send = advance && is_write && is_data
                       && (in_reg.side == dca_pkg::SIDE_SECOND);
        cmd1.rx_load = advance && is_write && is_data
                       && (in_reg.side == dca_pkg::SIDE_FIRST);
        cmd1.wdata   = in_reg.write_data;
    end

    dca_side u_side0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd0),
        .view    (view0)
    );

    dca_side u_side1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd1),
        .view    (view1)
    );

    assign view_sel = (in_reg.side == dca_pkg::SIDE_SECOND) ? view1 : view0;

    always_comb begin
        out_next = out_reg;
        if (advance) begin
            if (is_write) begin
                out_next.read_data = 8'h00;
            end else if (is_data) begin
                out_next.read_data = view_sel.rx_data;
            end else begin
                out_next.read_data = view_sel.status;
            end
            out_next.irq_first  = view0.status_next[7];
            out_next.irq_second = view1.status_next[7];
        end
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // input side stalls only when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a held result");

    // writes always return zero read data
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_write) |=> (out_reg.read_data == 8'h00))
        else $error("write item returned nonzero read data");

    // a data write lands in the other side's received byte
    a_crosslink: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_write && is_data && (in_reg.side == dca_pkg::SIDE_FIRST))
        |=> (view1.rx_data == $past(in_reg.write_data)))
        else $error("byte from first side not received by second side");

    // first side in master reset shows only transmit-empty after an update
    a_mreset: assert property (@(posedge aclk) disable iff (!aresetn)
        (needs_update && (view0.status_next[1:0] != 2'b00)
            && (cmd0.ctrl_we ? (cmd0.wdata[1:0] == dca_pkg::CT_MRESET)
                             : (view0.control[1:0] == dca_pkg::CT_MRESET)))
        |=> ((view0.status & ~dca_pkg::ST_IRQ) == dca_pkg::ST_TDRE))
        else $error("master reset did not force transmit-empty status");

endmodule
